// ----- rtl/ssm_pkg.sv -----
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared widths, register codes, constants and payload types of the steering
// servo mixer.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // Field widths
  localparam int PULSE_W    = 12;
  localparam int DIR_W      = 8;
  localparam int PCT_W      = 7;
  localparam int DZ_W       = 7;
  localparam int SLACK_W    = 10;
  localparam int TRIM_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  // Datapath widths
  localparam int K_W     = 7;   // ramp position and divider remainder
  localparam int SPAN_W  = 13;  // magnitude of max - min + slack
  localparam int PROD_W  = 19;  // ramp and brake products, below 2^19
  localparam int ADD_W   = 13;  // signed brake pull
  localparam int MIX_W   = 21;  // signed mixing sums

  // Divide by 100 through a reciprocal, exact for any value below 2^19
  localparam int                RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP_100  = 20'd671089;
  localparam int                RECIP_SHIFT = 26;

  // Ramp divider: quotient bits resolved per stage
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (PROD_W + DIV_STEP - 1) / DIV_STEP;

  // Register reset values
  localparam logic [PULSE_W-1:0]       RST_MIN_PULSE = 12'd1000;
  localparam logic [PULSE_W-1:0]       RST_MAX_PULSE = 12'd2000;
  localparam logic [PULSE_W-1:0]       RST_CUT_PULSE = 12'd1900;
  localparam logic [DZ_W-1:0]          RST_DEAD_ZONE = 7'd5;
  localparam logic [SLACK_W-1:0]       RST_SLACK     = 10'd0;
  localparam logic signed [TRIM_W-1:0] RST_TRIM      = 11'sd0;

  // Auxiliary channel end points
  localparam int AUX_ONE_LOW  = 1000;
  localparam int AUX_ONE_HIGH = 2000;
  localparam int AUX_TWO_LOW  = 1000;
  localparam int AUX_TWO_HIGH = 2000;

  localparam int AUX1_DIFF = AUX_ONE_HIGH - AUX_ONE_LOW;
  localparam int AUX2_DIFF = AUX_TWO_HIGH - AUX_TWO_LOW;
  localparam logic [PULSE_W-1:0] AUX1_MAG  = PULSE_W'((AUX1_DIFF < 0) ? -AUX1_DIFF : AUX1_DIFF);
  localparam logic [PULSE_W-1:0] AUX2_MAG  = PULSE_W'((AUX2_DIFF < 0) ? -AUX2_DIFF : AUX2_DIFF);
  localparam logic               AUX1_NEG  = (AUX1_DIFF < 0);
  localparam logic               AUX2_NEG  = (AUX2_DIFF < 0);
  localparam logic [PULSE_W-1:0] AUX1_BASE = PULSE_W'(AUX_ONE_LOW);
  localparam logic [PULSE_W-1:0] AUX2_BASE = PULSE_W'(AUX_TWO_LOW);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_PULSE = 3'd0,
    REG_MAX_PULSE = 3'd1,
    REG_CUT_PULSE = 3'd2,
    REG_DEAD_ZONE = 3'd3,
    REG_SLACK     = 3'd4,
    REG_TRIM      = 3'd5
  } cfg_idx_t;

  // Which side the steering ramp drives
  typedef enum logic [1:0] {
    SIDE_NEUTRAL,
    SIDE_LEFT,
    SIDE_RIGHT
  } side_t;

  typedef struct packed {
    logic [PULSE_W-1:0]       min_pulse;
    logic [PULSE_W-1:0]       max_pulse;
    logic [PULSE_W-1:0]       cut_pulse;
    logic [DZ_W-1:0]          dead_zone;
    logic [SLACK_W-1:0]       slack;
    logic signed [TRIM_W-1:0] trim;
  } ssm_cfg_t;

  // Values that ride alongside the divider
  typedef struct packed {
    side_t                    side;
    logic                     neg;
    logic signed [ADD_W-1:0]  add;
    logic [PULSE_W-1:0]       aux1;
    logic [PULSE_W-1:0]       aux2;
  } ssm_band_t;

  // Divider beat: num shifts dividend bits out and quotient bits in
  typedef struct packed {
    logic [PROD_W-1:0] num;
    logic [K_W-1:0]    rem;
    ssm_band_t         band;
  } ssm_div_t;

  // Clamp v between a and b, taking whichever is lower as the low bound
  function automatic logic [PULSE_W-1:0] ssm_clamp(input logic signed [MIX_W-1:0] v,
                                                   input logic [PULSE_W-1:0] a,
                                                   input logic [PULSE_W-1:0] b);
    logic [PULSE_W-1:0]      lo;
    logic [PULSE_W-1:0]      hi;
    logic signed [MIX_W-1:0] lo_s;
    logic signed [MIX_W-1:0] hi_s;
    lo   = (a > b) ? b : a;
    hi   = (a > b) ? a : b;
    lo_s = $signed(MIX_W'(lo));
    hi_s = $signed(MIX_W'(hi));
    if (v < lo_s) begin
      return lo;
    end else if (v > hi_s) begin
      return hi;
    end else begin
      return v[PULSE_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/ssm_front.sv -----
// ----------------------------------------------------------------------------
// ssm_front
// Three stages: saturate and pick the ramp side, form the ramp, brake and
// auxiliary products, then divide the brake and auxiliary products by 100.
// ----------------------------------------------------------------------------
module ssm_front
  import ssm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ssm_cfg_t                 cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DIR_W-1:0]  in_dir,
  input  logic [PCT_W-1:0]         in_brk,
  input  logic [PCT_W-1:0]         in_aux1,
  input  logic [PCT_W-1:0]         in_aux2,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ssm_div_t                 out_div
);

  localparam int AUXQ_W = PULSE_W;
  localparam int MUL_W  = PROD_W + RECIP_W;

  typedef struct packed {
    side_t            side;
    logic [K_W-1:0]   k;
    logic [PCT_W-1:0] brk;
    logic [PCT_W-1:0] aux1;
    logic [PCT_W-1:0] aux2;
  } stg_a_t;

  typedef struct packed {
    side_t             side;
    logic              neg;
    logic [PROD_W-1:0] pk;
    logic              bneg;
    logic [PROD_W-1:0] bp;
    logic [PROD_W-1:0] a1p;
    logic [PROD_W-1:0] a2p;
  } stg_b_t;

  typedef struct packed {
    side_t             side;
    logic              neg;
    logic [PROD_W-1:0] pk;
    logic              bneg;
    logic [AUXQ_W-1:0] bq;
    logic [AUXQ_W-1:0] a1q;
    logic [AUXQ_W-1:0] a2q;
  } stg_c_t;

  stg_a_t a_r, a_nxt;
  stg_b_t b_r, b_nxt;
  stg_c_t c_r, c_nxt;
  logic   a_vld_r, a_vld_nxt;
  logic   b_vld_r, b_vld_nxt;
  logic   c_vld_r, c_vld_nxt;
  logic   rdy_a, rdy_b, rdy_c;

  logic signed [DIR_W-1:0]  dir_s;
  logic signed [DIR_W:0]    dir9;
  logic signed [DIR_W:0]    dz9;
  logic signed [SPAN_W:0]   sr;
  logic [SPAN_W-1:0]        sr_mag;
  logic signed [PULSE_W:0]  bsp;
  logic [PULSE_W-1:0]       bsp_mag;
  logic [MUL_W-1:0]         bm, a1m, a2m;

  // Ready chain: a stage takes a beat when empty or when it moves on
  assign rdy_c    = !c_vld_r || out_ready;
  assign rdy_b    = !b_vld_r || rdy_c;
  assign rdy_a    = !a_vld_r || rdy_b;
  assign in_ready = rdy_a;

  assign a_vld_nxt = rdy_a ? in_valid : a_vld_r;
  assign b_vld_nxt = rdy_b ? a_vld_r  : b_vld_r;
  assign c_vld_nxt = rdy_c ? b_vld_r  : c_vld_r;

  // Stage A: saturate commands, pick ramp side and position
  always_comb begin
    dir_s = in_dir;
    if (in_dir > 8'sd100) begin
      dir_s = 8'sd100;
    end else if (in_dir < -8'sd100) begin
      dir_s = -8'sd100;
    end
    dir9 = (DIR_W+1)'(dir_s);
    dz9  = $signed({2'b00, cfg.dead_zone});
    a_nxt.brk  = (in_brk  > 7'd100) ? 7'd100 : in_brk;
    a_nxt.aux1 = (in_aux1 > 7'd100) ? 7'd100 : in_aux1;
    a_nxt.aux2 = (in_aux2 > 7'd100) ? 7'd100 : in_aux2;
    if (dir9 < -dz9) begin
      a_nxt.side = SIDE_LEFT;
      a_nxt.k    = K_W'(dir9 + 9'sd100);
    end else if (dir9 > dz9) begin
      a_nxt.side = SIDE_RIGHT;
      a_nxt.k    = K_W'(dir9 - dz9);
    end else begin
      a_nxt.side = SIDE_NEUTRAL;
      a_nxt.k    = '0;
    end
  end

  // Stage B: ramp, brake and auxiliary products on magnitudes
  always_comb begin
    sr = $signed({2'b00, cfg.max_pulse}) - $signed({2'b00, cfg.min_pulse})
         + $signed({4'b0000, cfg.slack});
    sr_mag  = sr[SPAN_W] ? SPAN_W'(-sr) : sr[SPAN_W-1:0];
    bsp     = $signed({1'b0, cfg.max_pulse}) - $signed({1'b0, cfg.min_pulse});
    bsp_mag = bsp[PULSE_W] ? PULSE_W'(-bsp) : bsp[PULSE_W-1:0];
    b_nxt.side = a_r.side;
    b_nxt.neg  = sr[SPAN_W] ^ (a_r.side == SIDE_LEFT);
    b_nxt.pk   = PROD_W'(a_r.k) * PROD_W'(sr_mag);
    b_nxt.bneg = bsp[PULSE_W];
    b_nxt.bp   = PROD_W'(a_r.brk) * PROD_W'(bsp_mag);
    b_nxt.a1p  = PROD_W'(a_r.aux1) * PROD_W'(AUX1_MAG);
    b_nxt.a2p  = PROD_W'(a_r.aux2) * PROD_W'(AUX2_MAG);
  end

  // Stage C: divide brake and auxiliary products by 100
  always_comb begin
    bm  = MUL_W'(b_r.bp)  * MUL_W'(RECIP_100);
    a1m = MUL_W'(b_r.a1p) * MUL_W'(RECIP_100);
    a2m = MUL_W'(b_r.a2p) * MUL_W'(RECIP_100);
    c_nxt.side = b_r.side;
    c_nxt.neg  = b_r.neg;
    c_nxt.pk   = b_r.pk;
    c_nxt.bneg = b_r.bneg;
    c_nxt.bq   = bm[RECIP_SHIFT +: AUXQ_W];
    c_nxt.a1q  = a1m[RECIP_SHIFT +: AUXQ_W];
    c_nxt.a2q  = a2m[RECIP_SHIFT +: AUXQ_W];
  end

  // Hand over to the divider: apply signs, add auxiliary bases
  always_comb begin
    out_div.num       = c_r.pk;
    out_div.rem       = '0;
    out_div.band.side = c_r.side;
    out_div.band.neg  = c_r.neg;
    out_div.band.add  = c_r.bneg ? -$signed({1'b0, c_r.bq}) : $signed({1'b0, c_r.bq});
    out_div.band.aux1 = AUX1_NEG ? (AUX1_BASE - c_r.a1q) : (AUX1_BASE + c_r.a1q);
    out_div.band.aux2 = AUX2_NEG ? (AUX2_BASE - c_r.a2q) : (AUX2_BASE + c_r.a2q);
  end
  assign out_valid = c_vld_r;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
      c_vld_r <= c_vld_nxt;
    end
  end

  // Load payload where a beat moves in
  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      a_r <= a_nxt;
    end
    if (rdy_b && a_vld_r) begin
      b_r <= b_nxt;
    end
    if (rdy_c && b_vld_r) begin
      c_r <= c_nxt;
    end
  end

  // A left ramp starts below full scale, a right ramp never at zero
  assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && (a_r.side == SIDE_LEFT) |-> (a_r.k < 7'd100))
    else $error("left ramp position out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && (a_r.side == SIDE_RIGHT) |-> (a_r.k != 7'd0) && (a_r.k <= 7'd100))
    else $error("right ramp position out of range");

endmodule

// ----- rtl/ssm_div_stage.sv -----
// ----------------------------------------------------------------------------
// ssm_div_stage
// One registered stage of the restoring ramp divider; resolves STEPS
// quotient bits and carries the side values along.
// ----------------------------------------------------------------------------
module ssm_div_stage
  import ssm_pkg::*;
#(
  parameter int STEPS = DIV_STEP
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [K_W-1:0] dvs,
  input  logic           in_valid,
  output logic           in_ready,
  input  ssm_div_t       in_div,
  output logic           out_valid,
  input  logic           out_ready,
  output ssm_div_t       out_div
);

  ssm_div_t     div_r, div_nxt;
  logic         vld_r, vld_nxt;
  logic [K_W:0] trial;

  assign in_ready = !vld_r || out_ready;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  // Shift in a dividend bit, subtract where the divisor fits
  always_comb begin
    div_nxt = in_div;
    trial   = '0;
    for (int i = 0; i < STEPS; i++) begin
      trial       = {div_nxt.rem, div_nxt.num[PROD_W-1]};
      div_nxt.num = {div_nxt.num[PROD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        div_nxt.rem    = K_W'(trial - {1'b0, dvs});
        div_nxt.num[0] = 1'b1;
      end else begin
        div_nxt.rem = trial[K_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      div_r <= div_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_div   = div_r;

endmodule

// ----- rtl/ssm_back.sv -----
// ----------------------------------------------------------------------------
// ssm_back
// Two stages: mix ramp and brake and clamp to the cut limit, then add trim,
// clamp to the servo range and hold the result beat.
// ----------------------------------------------------------------------------
module ssm_back
  import ssm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ssm_cfg_t           cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssm_div_t           in_div,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PULSE_W-1:0] out_left,
  output logic [PULSE_W-1:0] out_right,
  output logic [PULSE_W-1:0] out_aux1,
  output logic [PULSE_W-1:0] out_aux2
);

  typedef struct packed {
    logic [PULSE_W-1:0] left;
    logic [PULSE_W-1:0] right;
    logic [PULSE_W-1:0] aux1;
    logic [PULSE_W-1:0] aux2;
  } pulses_t;

  pulses_t mix_r, mix_nxt;
  pulses_t res_r, res_nxt;
  logic    mix_vld_r, mix_vld_nxt;
  logic    res_vld_r, res_vld_nxt;
  logic    rdy_mix, rdy_res;

  logic signed [MIX_W-1:0] qs, mn_s, mx_s, so_s, add_s, l_s, r_s;
  logic signed [MIX_W-1:0] tmag, delta, lt_s, rt_s;

  assign rdy_res  = !res_vld_r || out_ready;
  assign rdy_mix  = !mix_vld_r || rdy_res;
  assign in_ready = rdy_mix;

  assign mix_vld_nxt = rdy_mix ? in_valid  : mix_vld_r;
  assign res_vld_nxt = rdy_res ? mix_vld_r : res_vld_r;

  // Mix ramp with rest pulse, add brake, clamp to cut limit
  always_comb begin
    qs    = in_div.band.neg ? -$signed(MIX_W'(in_div.num)) : $signed(MIX_W'(in_div.num));
    mn_s  = $signed(MIX_W'(cfg.min_pulse));
    mx_s  = $signed(MIX_W'(cfg.max_pulse));
    so_s  = $signed(MIX_W'(cfg.slack));
    add_s = MIX_W'(in_div.band.add);
    case (in_div.band.side)
      SIDE_LEFT: begin
        l_s = mx_s + qs;
        r_s = mn_s;
      end
      SIDE_RIGHT: begin
        l_s = mn_s;
        r_s = mn_s - so_s + qs;
      end
      default: begin
        l_s = mn_s;
        r_s = mn_s;
      end
    endcase
    mix_nxt.left  = ssm_clamp(l_s + add_s, cfg.min_pulse, cfg.cut_pulse);
    mix_nxt.right = ssm_clamp(r_s + add_s, cfg.min_pulse, cfg.cut_pulse);
    mix_nxt.aux1  = in_div.band.aux1;
    mix_nxt.aux2  = in_div.band.aux2;
  end

  // Add trim to one side, signed by servo direction, clamp to servo range
  always_comb begin
    tmag  = cfg.trim[TRIM_W-1] ? -MIX_W'(cfg.trim) : MIX_W'(cfg.trim);
    delta = (cfg.max_pulse < cfg.min_pulse) ? -tmag : tmag;
    lt_s  = $signed(MIX_W'(mix_r.left));
    rt_s  = $signed(MIX_W'(mix_r.right));
    if (cfg.trim < 0) begin
      lt_s = lt_s + delta;
    end
    if (cfg.trim > 0) begin
      rt_s = rt_s + delta;
    end
    res_nxt.left  = ssm_clamp(lt_s, cfg.min_pulse, cfg.max_pulse);
    res_nxt.right = ssm_clamp(rt_s, cfg.min_pulse, cfg.max_pulse);
    res_nxt.aux1  = mix_r.aux1;
    res_nxt.aux2  = mix_r.aux2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      mix_vld_r <= mix_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_mix && in_valid) begin
      mix_r <= mix_nxt;
    end
    if (rdy_res && mix_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_vld_r;
  assign out_left  = res_r.left;
  assign out_right = res_r.right;
  assign out_aux1  = res_r.aux1;
  assign out_aux2  = res_r.aux2;

  // Reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

endmodule

// ----- rtl/steering_servo_mixer.sv -----
// ----------------------------------------------------------------------------
// steering_servo_mixer
// Path: front, divider and back stages, all registered. Throughput: one beat
// per cycle while out_tready holds; the restoring ramp divider is split over
// five registered stages and every stage moves on when it is empty or drained.
// Reset: synchronous active-low rst_n empties the pipeline and loads the
// register defaults; cfg_ready stays high.
// ----------------------------------------------------------------------------
module steering_servo_mixer
  import ssm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // direction, brake, aux1_level, aux2_level
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // left_pulse, right_pulse, aux1_pulse, aux2_pulse
);

  ssm_cfg_t cfg_r, cfg_nxt;

  logic       vld_w [DIV_STAGES+1];
  logic       rdy_w [DIV_STAGES+1];
  ssm_div_t   div_w [DIV_STAGES+1];
  logic [K_W-1:0] dvs;

  logic [PULSE_W-1:0] left_pulse, right_pulse, aux1_pulse, aux2_pulse;

  // Register writes; indexes past the list are dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_MIN_PULSE: cfg_nxt.min_pulse = cfg_data[PULSE_W-1:0];
        REG_MAX_PULSE: cfg_nxt.max_pulse = cfg_data[PULSE_W-1:0];
        REG_CUT_PULSE: cfg_nxt.cut_pulse = cfg_data[PULSE_W-1:0];
        REG_DEAD_ZONE: cfg_nxt.dead_zone = cfg_data[DZ_W-1:0];
        REG_SLACK:     cfg_nxt.slack     = cfg_data[SLACK_W-1:0];
        REG_TRIM:      cfg_nxt.trim      = $signed(cfg_data[TRIM_W-1:0]);
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_pulse <= RST_MIN_PULSE;
      cfg_r.max_pulse <= RST_MAX_PULSE;
      cfg_r.cut_pulse <= RST_CUT_PULSE;
      cfg_r.dead_zone <= RST_DEAD_ZONE;
      cfg_r.slack     <= RST_SLACK;
      cfg_r.trim      <= RST_TRIM;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Ramp divisor, only meaningful when the direction is past the dead zone
  assign dvs = K_W'(7'd100 - cfg_r.dead_zone);

  ssm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_dir    ($signed(in_tdata[7:0])),
    .in_brk    (in_tdata[14:8]),
    .in_aux1   (in_tdata[21:15]),
    .in_aux2   (in_tdata[28:22]),
    .out_valid (vld_w[0]),
    .out_ready (rdy_w[0]),
    .out_div   (div_w[0])
  );

  // Divider stages, the last one takes the remaining quotient bits
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    localparam int LEFT_BITS = PROD_W - s * DIV_STEP;
    localparam int STEPS     = (LEFT_BITS < DIV_STEP) ? LEFT_BITS : DIV_STEP;

    ssm_div_stage #(
      .STEPS (STEPS)
    ) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .dvs       (dvs),
      .in_valid  (vld_w[s]),
      .in_ready  (rdy_w[s]),
      .in_div    (div_w[s]),
      .out_valid (vld_w[s+1]),
      .out_ready (rdy_w[s+1]),
      .out_div   (div_w[s+1])
    );
  end

  ssm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (vld_w[DIV_STAGES]),
    .in_ready  (rdy_w[DIV_STAGES]),
    .in_div    (div_w[DIV_STAGES]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_left  (left_pulse),
    .out_right (right_pulse),
    .out_aux1  (aux1_pulse),
    .out_aux2  (aux2_pulse)
  );

  assign out_tdata = {aux2_pulse, aux1_pulse, right_pulse, left_pulse};

  // Input only backs up once every stage holds a beat and the output is stalled
  assert property (@(posedge clk) disable iff (!rst_n) !in_tready |-> out_tvalid)
    else $error("input stalled with room left in the pipeline");

endmodule
